### rtl/frwl_pkg.sv
`default_nettype none

package frwl_pkg;

  // Queue geometry and field widths
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned ID_BITS     = 6;
  localparam int unsigned QW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW          = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RCW         = 7;
  localparam logic [RCW-1:0] RC_MAX   = '1;

  // Request codes
  typedef enum logic [1:0] {
    REQ_RD_LOCK   = 2'd0,
    REQ_WR_LOCK   = 2'd1,
    REQ_RD_UNLOCK = 2'd2,
    REQ_WR_UNLOCK = 2'd3
  } req_e;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_GRANTED   = 3'd0,
    STAT_QUEUED    = 3'd1,
    STAT_RELEASED  = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_PROTO_ERR = 3'd4
  } status_e;

  // Result kinds
  localparam logic KIND_OUTCOME = 1'b0;
  localparam logic KIND_GRANT   = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_DRAIN
  } state_e;

  // One wait queue entry
  typedef struct packed {
    logic               is_write;
    logic [ID_BITS-1:0] id;
  } entry_t;

endpackage

`default_nettype wire

### rtl/fifo_fair_reader_writer_lock.sv
`default_nettype none

// Fair FIFO reader-writer lock manager.
// Command channel: present req_type_i and requester_id_i with start_i; the
// request is taken at a clock edge where start_i is high and busy_o is low.
// busy_o stays high until every result of that request has been shown.
// Result channel: each result is on the result ports for one cycle, marked
// by result_valid_o; last_o flags the final result of a request. The first
// result is the outcome of the request, each following one names a queued
// waiter that the request's release granted.
// Timing: the request passes through S_FETCH, which reads the queue head
// from the wait-queue RAM, and S_EXEC, which decides and shows the outcome.
// A release that grants waiters then stays in S_DRAIN, one grant per cycle
// as the drain walks the head of the queue RAM; a new request is not taken
// until the last result of the current one has been shown.
// Reset clears the holder state and the queue pointers; the queue RAM itself
// is not cleared, as entries are only read after being written.
// Results cannot be held off by the receiver.
module fifo_fair_reader_writer_lock (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [1:0]                   req_type_i,
  input  wire logic [frwl_pkg::ID_BITS-1:0] requester_id_i,
  output logic                              result_valid_o,
  output logic                              result_kind_o,
  output logic [frwl_pkg::ID_BITS-1:0]      target_id_o,
  output logic                              grant_is_write_o,
  output logic [2:0]                        status_o,
  output logic                              last_o
);
  import frwl_pkg::*;

  function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
    ptr_inc = (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
  endfunction

  state_e state_q, state_d;

  req_e               req_q;
  logic [ID_BITS-1:0] id_q;

  logic [RCW-1:0] rc_q, rc_d;
  logic           wa_q, wa_d;
  logic [QW-1:0]  head_q, head_d;
  logic [QW-1:0]  tail_q, tail_d;
  logic [CW-1:0]  count_q, count_d;

  entry_t         mem_q [QUEUE_DEPTH];
  entry_t         rd0_q, rd1_q;
  logic [QW-1:0]  rd_addr0, rd_addr1;
  logic           wr_en;
  entry_t         wr_data;

  logic    conflict, is_lock, idle_lock, full, rel_ok, allow_wr;
  logic    drain_any, exec_drain, drain_more;
  status_e exec_status;

  // Decode the request against the current holder and queue state
  always_comb begin
    conflict  = (rc_q != '0) && wa_q;
    is_lock   = (req_q == REQ_RD_LOCK) || (req_q == REQ_WR_LOCK);
    idle_lock = (count_q == '0) && (rc_q == '0) && !wa_q;
    full      = count_q >= CW'(QUEUE_DEPTH);
    rel_ok    = (req_q == REQ_RD_UNLOCK) ? (rc_q != '0) : wa_q;
    allow_wr  = (req_q == REQ_RD_UNLOCK) ? (rc_q == RCW'(1)) : 1'b1;
    drain_any = (count_q != '0) && (!rd0_q.is_write || allow_wr);
    exec_drain = !conflict && !is_lock && rel_ok && drain_any;
    drain_more = !rd0_q.is_write && (count_q > CW'(1)) && !rd1_q.is_write;

    if (conflict) begin
      exec_status = STAT_PROTO_ERR;
    end else if (is_lock) begin
      if (idle_lock) begin
        exec_status = STAT_GRANTED;
      end else if (full) begin
        exec_status = STAT_FULL;
      end else begin
        exec_status = STAT_QUEUED;
      end
    end else begin
      exec_status = rel_ok ? STAT_RELEASED : STAT_PROTO_ERR;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_FETCH;
      end
      S_FETCH: state_d = S_EXEC;
      S_EXEC: begin
        state_d = exec_drain ? S_DRAIN : S_IDLE;
      end
      S_DRAIN: begin
        state_d = drain_more ? S_DRAIN : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy_o           = (state_q != S_IDLE);
    result_valid_o   = 1'b0;
    result_kind_o    = KIND_OUTCOME;
    target_id_o      = id_q;
    grant_is_write_o = 1'b0;
    status_o         = STAT_GRANTED;
    last_o           = 1'b0;
    case (state_q)
      S_EXEC: begin
        result_valid_o   = 1'b1;
        status_o         = exec_status;
        grant_is_write_o = (exec_status == STAT_GRANTED) && (req_q == REQ_WR_LOCK);
        last_o           = !exec_drain;
      end
      S_DRAIN: begin
        result_valid_o   = 1'b1;
        result_kind_o    = KIND_GRANT;
        target_id_o      = rd0_q.id;
        grant_is_write_o = rd0_q.is_write;
        last_o           = !drain_more;
      end
      default: ;
    endcase
  end

  // Holder and queue pointer updates
  always_comb begin
    rc_d    = rc_q;
    wa_d    = wa_q;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    wr_en   = 1'b0;
    wr_data = '{is_write: (req_q == REQ_WR_LOCK), id: id_q};
    case (state_q)
      S_EXEC: begin
        if (!conflict) begin
          if (is_lock) begin
            if (idle_lock) begin
              if (req_q == REQ_WR_LOCK) wa_d = 1'b1;
              else rc_d = RCW'(1);
            end else if (!full) begin
              wr_en   = 1'b1;
              tail_d  = ptr_inc(tail_q);
              count_d = count_q + CW'(1);
            end
          end else if (rel_ok) begin
            if (req_q == REQ_RD_UNLOCK) rc_d = rc_q - RCW'(1);
            else wa_d = 1'b0;
          end
        end
      end
      S_DRAIN: begin
        head_d  = ptr_inc(head_q);
        count_d = count_q - CW'(1);
        if (rd0_q.is_write) begin
          wa_d = 1'b1;
        end else if (rc_q != RC_MAX) begin
          rc_d = rc_q + RCW'(1);
        end
      end
      default: ;
    endcase
    rd_addr0 = head_d;
    rd_addr1 = ptr_inc(head_d);
  end

  // Wait queue RAM: one write port, two registered read ports at the head
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[tail_q] <= wr_data;
    rd0_q <= mem_q[rd_addr0];
    rd1_q <= mem_q[rd_addr1];
  end

  // Capture the command on transfer
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      req_q <= req_e'(req_type_i);
      id_q  <= requester_id_i;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rc_q    <= '0;
      wa_q    <= 1'b0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      rc_q    <= rc_d;
      wa_q    <= wa_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

### tb/sv/fifo_fair_reader_writer_lock_test.sv
`timescale 1ns / 1ps

module fifo_fair_reader_writer_lock_test;
  import frwl_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES = 4;

  // One result as seen on the result ports
  typedef struct {
    logic               kind;
    logic [ID_BITS-1:0] id;
    logic               wr;
    status_e            st;
    logic               last;
  } lock_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  req_e               req_type;
  logic [ID_BITS-1:0] requester_id;
  logic               result_valid_o;
  logic               result_kind_o;
  logic [ID_BITS-1:0] target_id_o;
  logic               grant_is_write_o;
  logic [2:0]         status_o;
  logic               last_o;

  // Lock state as the block should hold it
  logic [RCW-1:0]     held_readers;
  logic               writer_holds;
  entry_t             waiters [QUEUE_DEPTH];
  logic [QW-1:0]      wait_head;
  logic [QW-1:0]      wait_tail;
  logic [CW-1:0]      wait_count;

  lock_result_t       pending_results [$];
  int unsigned        mismatch_count;
  int unsigned        stall_cycles;
  bit                 sender_idles;

  fifo_fair_reader_writer_lock u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .req_type_i       (req_type),
    .requester_id_i   (requester_id),
    .result_valid_o   (result_valid_o),
    .result_kind_o    (result_kind_o),
    .target_id_o      (target_id_o),
    .grant_is_write_o (grant_is_write_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic lock_result_t make_result(logic kind, logic [ID_BITS-1:0] id,
                                               logic wr, status_e st);
    lock_result_t r;
    r.kind = kind;
    r.id   = id;
    r.wr   = wr;
    r.st   = st;
    r.last = 1'b0;
    return r;
  endfunction

  // Work out the outcome and grants of one accepted request, update the state
  task automatic predict_lock_response(req_e kind, logic [ID_BITS-1:0] id);
    lock_result_t burst [QUEUE_DEPTH + 1];
    lock_result_t r;
    int           n;
    logic         do_drain;
    logic         allow_writer;
    n = 1;
    do_drain = 1'b0;
    allow_writer = 1'b0;
    burst[0] = make_result(KIND_OUTCOME, id, 1'b0, STAT_PROTO_ERR);
    if (held_readers != '0 && writer_holds) begin
      // readers and writer both holding: reject everything, keep state
    end else if (kind == REQ_RD_LOCK || kind == REQ_WR_LOCK) begin
      if (wait_count == '0 && held_readers == '0 && !writer_holds) begin
        if (kind == REQ_WR_LOCK) writer_holds = 1'b1;
        else held_readers = RCW'(1);
        burst[0] = make_result(KIND_OUTCOME, id, kind == REQ_WR_LOCK, STAT_GRANTED);
      end else if (wait_count >= QUEUE_DEPTH) begin
        burst[0] = make_result(KIND_OUTCOME, id, 1'b0, STAT_FULL);
      end else begin
        waiters[wait_tail] = {kind == REQ_WR_LOCK, id};
        wait_tail = (wait_tail == QUEUE_DEPTH - 1) ? '0 : wait_tail + 1'b1;
        wait_count = wait_count + 1'b1;
        burst[0] = make_result(KIND_OUTCOME, id, 1'b0, STAT_QUEUED);
      end
    end else if (kind == REQ_RD_UNLOCK) begin
      if (held_readers != '0) begin
        held_readers = held_readers - 1'b1;
        burst[0] = make_result(KIND_OUTCOME, id, 1'b0, STAT_RELEASED);
        do_drain = 1'b1;
        allow_writer = (held_readers == '0);
      end
    end else if (writer_holds) begin
      writer_holds = 1'b0;
      burst[0] = make_result(KIND_OUTCOME, id, 1'b0, STAT_RELEASED);
      do_drain = 1'b1;
      allow_writer = 1'b1;
    end

    // Grant the leading run of readers, or a writer at the head when allowed
    if (do_drain && wait_count != '0) begin
      if (waiters[wait_head].is_write) begin
        if (allow_writer) begin
          burst[n] = make_result(KIND_GRANT, waiters[wait_head].id, 1'b1, STAT_GRANTED);
          n++;
          wait_head = (wait_head == QUEUE_DEPTH - 1) ? '0 : wait_head + 1'b1;
          wait_count = wait_count - 1'b1;
          writer_holds = 1'b1;
        end
      end else begin
        while (wait_count != '0 && !waiters[wait_head].is_write) begin
          burst[n] = make_result(KIND_GRANT, waiters[wait_head].id, 1'b0, STAT_GRANTED);
          n++;
          wait_head = (wait_head == QUEUE_DEPTH - 1) ? '0 : wait_head + 1'b1;
          wait_count = wait_count - 1'b1;
          if (held_readers != RC_MAX) held_readers = held_readers + 1'b1;
        end
      end
    end

    for (int i = 0; i < n; i++) begin
      r = burst[i];
      r.last = (i == n - 1);
      pending_results.push_back(r);
    end
  endtask

  // Present one request and hold it until the block takes the transfer
  task automatic send_request(req_e kind, logic [ID_BITS-1:0] id);
    if (sender_idles && $urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i      <= 1'b1;
    req_type     <= kind;
    requester_id <= id;
    do @(posedge clk_i); while (busy_o);
    predict_lock_response(kind, id);
    @(negedge clk_i);
    start_i      <= 1'b0;
    req_type     <= req_e'($urandom_range(0, 3));
    requester_id <= ID_BITS'($urandom_range(0, 63));
  endtask

  // Hold off until every expected result has come back, then let the block settle
  task automatic wait_for_drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, what);
  endtask

  // Unlocks with nothing held answer a protocol error
  task automatic test_unheld_releases();
    send_request(REQ_WR_UNLOCK, 6'd0);
    send_request(REQ_RD_UNLOCK, 6'd63);
  endtask

  // Writer hands off to a queued reader, which then hands off to a queued writer
  task automatic test_writer_handoff();
    send_request(REQ_WR_LOCK, 6'd63);
    send_request(REQ_RD_LOCK, 6'd0);
    send_request(REQ_WR_LOCK, 6'd42);
    send_request(REQ_RD_UNLOCK, 6'd21);
    send_request(REQ_WR_UNLOCK, 6'd63);
    send_request(REQ_RD_UNLOCK, 6'd0);
    send_request(REQ_WR_UNLOCK, 6'd42);
  endtask

  // Fill the queue with readers, overflow it, then release all waiters at once
  task automatic test_full_queue_burst();
    send_request(REQ_RD_LOCK, 6'd1);
    for (int i = 0; i < QUEUE_DEPTH; i++) send_request(REQ_RD_LOCK, 6'(i + 2));
    send_request(REQ_RD_LOCK, 6'd18);
    send_request(REQ_WR_LOCK, 6'd19);
    send_request(REQ_RD_UNLOCK, 6'd1);
  endtask

  // Mostly lock/unlock traffic that matches the current holder, some noise
  task automatic test_random_traffic(int unsigned n_items);
    req_e               kind;
    logic [ID_BITS-1:0] id;
    int unsigned        pick;
    for (int i = 0; i < n_items; i++) begin
      if (i % 25 == 0) sender_idles = ($urandom_range(0, 3) != 0);
      if (i == n_items / 2) wait_for_drain();
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0: id = '0;
        1: id = '1;
        default: id = ID_BITS'($urandom_range(0, 63));
      endcase
      if (pick < 45) begin
        kind = ($urandom_range(0, 9) < 6) ? REQ_RD_LOCK : REQ_WR_LOCK;
      end else if (pick < 88) begin
        if (writer_holds) kind = REQ_WR_UNLOCK;
        else if (held_readers != '0) kind = REQ_RD_UNLOCK;
        else kind = req_e'($urandom_range(2, 3));
      end else begin
        kind = req_e'($urandom_range(0, 3));
      end
      send_request(kind, id);
    end
  endtask

  // Release everything, then grow the reader count in rounds until it saturates at RC_MAX
  task automatic test_reader_saturation();
    while (wait_count != '0 || held_readers != '0 || writer_holds) begin
      send_request(writer_holds ? REQ_WR_UNLOCK : REQ_RD_UNLOCK,
                   ID_BITS'($urandom_range(0, 63)));
    end
    send_request(REQ_RD_LOCK, ID_BITS'($urandom_range(0, 63)));
    repeat (11) begin
      repeat (QUEUE_DEPTH - 1) send_request(REQ_RD_LOCK, ID_BITS'($urandom_range(0, 63)));
      send_request(REQ_RD_UNLOCK, ID_BITS'($urandom_range(0, 63)));
    end
    repeat (3) send_request(REQ_RD_UNLOCK, ID_BITS'($urandom_range(0, 63)));
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin : check_results
    lock_result_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d id=%0d wr=%0d st=%0d last=%0d",
                                  result_kind_o, target_id_o, grant_is_write_o, status_o,
                                  last_o));
      end else begin
        exp_r = pending_results.pop_front();
        if (result_kind_o !== exp_r.kind || target_id_o !== exp_r.id ||
            grant_is_write_o !== exp_r.wr || status_o !== exp_r.st ||
            last_o !== exp_r.last) begin
          report_mismatch($sformatf(
            "result mismatch exp kind=%0d id=%0d wr=%0d st=%0d last=%0d, got %0d %0d %0d %0d %0d",
            exp_r.kind, exp_r.id, exp_r.wr, exp_r.st, exp_r.last,
            result_kind_o, target_id_o, grant_is_write_o, status_o, last_o));
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("fifo_fair_reader_writer_lock_test failed");
      $finish;
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    req_type       <= REQ_RD_LOCK;
    requester_id   <= '0;
    held_readers   = '0;
    writer_holds   = 1'b0;
    wait_head      = '0;
    wait_tail      = '0;
    wait_count     = '0;
    mismatch_count = 0;
    stall_cycles   = 0;
    sender_idles   = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_unheld_releases();
    test_writer_handoff();
    test_full_queue_burst();
    test_random_traffic(160);
    sender_idles = 1'b0;
    test_reader_saturation();

    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("fifo_fair_reader_writer_lock_test passed");
    end else begin
      $display("fifo_fair_reader_writer_lock_test failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/frwl_pkg.sv
rtl/fifo_fair_reader_writer_lock.sv
tb/sv/fifo_fair_reader_writer_lock_test.sv
